// File: hw/rtl/mp2d_pkg.sv
// Shared types, constants and helpers of the streaming max-pooling block.
package mp2d_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_POOL    = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int ROW_LIMIT   = 256;
	localparam int LINES       = MAX_POOL - 1;

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int ROW_BITS  = $clog2(ROW_LIMIT);
	localparam int SLOT_BITS = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int PH_BITS   = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
	localparam int DIM_BITS  = 9;
	localparam int POOL_BITS = 3;
	localparam int CFG_BITS  = 9;
	localparam int CALC_BITS = ((COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS) + 3;

	localparam logic [DIM_BITS-1:0]  RST_PLANE_WIDTH  = 9'd8;
	localparam logic [DIM_BITS-1:0]  RST_PLANE_HEIGHT = 9'd8;
	localparam logic [POOL_BITS-1:0] RST_POOL_SIZE    = 3'd2;
	localparam logic [POOL_BITS-1:0] RST_STRIDE       = 3'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		REG_PLANE_WIDTH  = 2'd0,
		REG_PLANE_HEIGHT = 2'd1,
		REG_POOL_SIZE    = 2'd2,
		REG_STRIDE       = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_LOAD  = 3'b010,
		ST_ALIGN = 3'b100
	} align_state_t;

	typedef struct packed {
		logic shift;
		logic take;
	} cell_ctrl_t;

	function automatic sample_t smax(input sample_t a, input sample_t b);
		return (b > a) ? b : a;
	endfunction

endpackage

// File: hw/rtl/mp2d_if.sv
// Handshake channels of the max-pooling block: samples in, pooled items out, register writes.
interface mp2d_feed_if;
	logic                 valid;
	logic                 ready;
	mp2d_pkg::sample_t    sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mp2d_pooled_if;
	logic                 valid;
	logic                 ready;
	mp2d_pkg::sample_t    pooled_value;
	logic                 plane_last;

	modport source (output valid, output pooled_value, output plane_last, input ready);
	modport sink (input valid, input pooled_value, input plane_last, output ready);
endinterface

interface mp2d_cfg_if;
	logic                              valid;
	logic                              ready;
	mp2d_pkg::cfg_reg_t                index;
	logic [mp2d_pkg::CFG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/mp2d_ram.sv
// Generic single-write, single-read RAM with registered read data (old data on collision).
module mp2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// File: hw/rtl/mp2d_cell.sv
// One cell of the horizontal window chain: holds a recent sample and folds it into the running max.
module mp2d_cell (
	input  logic                 clk,
	input  mp2d_pkg::cell_ctrl_t ctrl,
	input  mp2d_pkg::sample_t    sample_in,
	output mp2d_pkg::sample_t    sample_out,
	input  mp2d_pkg::sample_t    max_in,
	output mp2d_pkg::sample_t    max_out
);

	mp2d_pkg::sample_t sample_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			sample_q <= sample_in;
		end
	end

	assign sample_out = sample_q;
	assign max_out    = ctrl.take ? mp2d_pkg::smax(max_in, sample_q) : max_in;

endmodule

// File: hw/rtl/max_pool_2d_stream_core.sv
// Top level of the streaming 2-D max-pooling block.
//
//  channel | dir | payload                     | accepted when
//  feed    | in  | sample                      | feed.valid && feed.ready
//  pooled  | out | pooled_value, plane_last    | pooled.valid && pooled.ready
//  cfg     | in  | index, data                 | cfg.valid && cfg.ready (always ready)
//
// One sample per cycle while feed.ready is high; results pass stage 1, then the output register.
// The horizontal max runs through a chain of cells; the vertical max reads one line RAM per
// kept row at the sample's column, registered, and is folded in the second stage.
// After reset and between planes no realignment is needed; each configuration write starts a
// realignment of the window phases, through ST_LOAD and ST_ALIGN, with feed.ready low.
// A stalled output register holds stage 1, which then holds feed.ready low.
module max_pool_2d_stream_core (
	input  logic clk,
	input  logic arst_n,
	mp2d_feed_if.sink     feed,
	mp2d_pooled_if.source pooled,
	mp2d_cfg_if.sink      cfg
);

	localparam int LINES     = mp2d_pkg::LINES;
	localparam int COL_BITS  = mp2d_pkg::COL_BITS;
	localparam int ROW_BITS  = mp2d_pkg::ROW_BITS;
	localparam int SLOT_BITS = mp2d_pkg::SLOT_BITS;
	localparam int PH_BITS   = mp2d_pkg::PH_BITS;
	localparam int CALC_BITS = mp2d_pkg::CALC_BITS;

	typedef logic [CALC_BITS-1:0] calc_t;

	// configuration
	logic [mp2d_pkg::DIM_BITS-1:0]  plane_width_q, plane_height_q;
	logic [mp2d_pkg::POOL_BITS-1:0] pool_size_q, stride_q;
	calc_t w_c, h_c, p_c, s_c;

	// position and phases
	mp2d_pkg::align_state_t state_q;
	logic [COL_BITS-1:0]  col_q, c_n, c_next;
	logic [ROW_BITS-1:0]  row_q, r_n, r_next;
	logic [SLOT_BITS-1:0] slot_q, slot_n, slot_next;
	logic [PH_BITS-1:0]   ph_c_q, ph_r_q, ph_c_next, ph_r_next, a_c, a_r;
	calc_t c_c, r_c, r_tmp;
	logic c_wrap, r_wrap, col_full, row_full, row_end, plane_end;
	logic produce, is_last, accept, s1_go;

	// datapath
	mp2d_pkg::sample_t    x, hmax, vmax;
	mp2d_pkg::sample_t    cell_sample [LINES];
	mp2d_pkg::sample_t    cell_max [LINES];
	mp2d_pkg::cell_ctrl_t cell_ctrl [LINES];
	logic [mp2d_pkg::SAMPLE_BITS-1:0] line_rd [LINES];
	logic [SLOT_BITS-1:0] src_slot_n [LINES];
	logic [LINES-1:0]     take_rows_n;

	// stage 1 and output register
	logic                 valid_s1, produce_s1, last_s1;
	mp2d_pkg::sample_t    hmax_s1;
	logic [SLOT_BITS-1:0] src_slot_s1 [LINES];
	logic [LINES-1:0]     take_rows_s1;
	logic                 out_valid_q, plane_last_q;
	mp2d_pkg::sample_t    pooled_value_q;

	// effective register values
	always_comb begin
		if (plane_width_q == '0) begin
			w_c = calc_t'(1);
		end else if (32'(plane_width_q) > mp2d_pkg::MAX_WIDTH) begin
			w_c = calc_t'(mp2d_pkg::MAX_WIDTH);
		end else begin
			w_c = calc_t'(plane_width_q);
		end
		if (plane_height_q == '0) begin
			h_c = calc_t'(1);
		end else if (32'(plane_height_q) > mp2d_pkg::ROW_LIMIT) begin
			h_c = calc_t'(mp2d_pkg::ROW_LIMIT);
		end else begin
			h_c = calc_t'(plane_height_q);
		end
		if (pool_size_q == '0) begin
			p_c = calc_t'(1);
		end else if (32'(pool_size_q) > mp2d_pkg::MAX_POOL) begin
			p_c = calc_t'(mp2d_pkg::MAX_POOL);
		end else begin
			p_c = calc_t'(pool_size_q);
		end
		s_c = (stride_q == '0) ? calc_t'(1) : calc_t'(stride_q);
	end

	// position of this sample, with a stale position folded into a new row or plane
	always_comb begin
		c_wrap = calc_t'(col_q) >= w_c;
		c_n    = c_wrap ? '0 : col_q;
		r_tmp  = calc_t'(row_q) + calc_t'(c_wrap);
		r_wrap = r_tmp >= h_c;
		r_n    = r_wrap ? '0 : ROW_BITS'(r_tmp);
		if (r_wrap) begin
			slot_n = '0;
		end else if (c_wrap) begin
			slot_n = (slot_q == SLOT_BITS'(LINES - 1)) ? '0 : SLOT_BITS'(slot_q + 1'b1);
		end else begin
			slot_n = slot_q;
		end
		c_c = calc_t'(c_n);
		r_c = calc_t'(r_n);

		col_full  = c_c + 1 >= p_c;
		row_full  = r_c + 1 >= p_c;
		produce   = col_full && row_full && ph_c_q == '0 && ph_r_q == '0;
		is_last   = (c_c + 1 + s_c > w_c) && (r_c + 1 + s_c > h_c);
		row_end   = c_c + 1 >= w_c;
		plane_end = r_c + 1 >= h_c;

		c_next = row_end ? '0 : COL_BITS'(c_c + 1);
		if (!row_end) begin
			r_next    = r_n;
			slot_next = slot_n;
		end else if (plane_end) begin
			r_next    = '0;
			slot_next = '0;
		end else begin
			r_next    = ROW_BITS'(r_c + 1);
			slot_next = (slot_n == SLOT_BITS'(LINES - 1)) ? '0 : SLOT_BITS'(slot_n + 1'b1);
		end

		// restart the phase where the first window starts, else count modulo stride
		ph_c_next = (calc_t'(c_next) + 1 == p_c || calc_t'(ph_c_q) + 1 >= s_c) ?
			'0 : PH_BITS'(ph_c_q + 1'b1);
		ph_r_next = (calc_t'(r_next) + 1 == p_c || calc_t'(ph_r_q) + 1 >= s_c) ?
			'0 : PH_BITS'(ph_r_q + 1'b1);

		a_c = col_full ? PH_BITS'(c_c + 1 - p_c) : '0;
		a_r = row_full ? PH_BITS'(r_c + 1 - p_c) : '0;
	end

	assign s1_go      = !out_valid_q || pooled.ready;
	assign feed.ready = (state_q == mp2d_pkg::ST_RUN) && (!valid_s1 || s1_go);
	assign accept     = feed.valid && feed.ready;
	assign cfg.ready  = 1'b1;
	assign x          = feed.sample;

	// horizontal window: chain of cells
	for (genvar k = 0; k < LINES; k++) begin : g_cell
		assign cell_ctrl[k].shift = accept;
		assign cell_ctrl[k].take  = col_full && (calc_t'(k + 1) < p_c);
		if (k == 0) begin : g_head
			mp2d_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[k]),
				.sample_in  (x),
				.sample_out (cell_sample[k]),
				.max_in     (x),
				.max_out    (cell_max[k])
			);
		end else begin : g_body
			mp2d_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[k]),
				.sample_in  (cell_sample[k-1]),
				.sample_out (cell_sample[k]),
				.max_in     (cell_max[k-1]),
				.max_out    (cell_max[k])
			);
		end
	end
	assign hmax = cell_max[LINES-1];

	// one line RAM per kept row of horizontal maxima
	for (genvar i = 0; i < LINES; i++) begin : g_line
		mp2d_ram #(
			.WIDTH (mp2d_pkg::SAMPLE_BITS),
			.DEPTH (mp2d_pkg::MAX_WIDTH)
		) u_line (
			.clk   (clk),
			.we    (accept && slot_n == SLOT_BITS'(i)),
			.waddr (c_n),
			.wdata (hmax),
			.re    (accept),
			.raddr (c_n),
			.rdata (line_rd[i])
		);
	end

	// slot holding row r-(j+1), and whether that row lies in the window
	always_comb begin
		int t;
		for (int j = 0; j < LINES; j++) begin
			t = int'(slot_n) + LINES - 1 - j;
			if (t >= LINES) begin
				t = t - LINES;
			end
			src_slot_n[j]  = SLOT_BITS'(t);
			take_rows_n[j] = calc_t'(j + 1) < p_c;
		end
	end

	always_comb begin
		vmax = hmax_s1;
		for (int j = 0; j < LINES; j++) begin
			if (take_rows_s1[j]) begin
				vmax = mp2d_pkg::smax(vmax, mp2d_pkg::sample_t'(line_rd[src_slot_s1[j]]));
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_width_q  <= mp2d_pkg::RST_PLANE_WIDTH;
			plane_height_q <= mp2d_pkg::RST_PLANE_HEIGHT;
			pool_size_q    <= mp2d_pkg::RST_POOL_SIZE;
			stride_q       <= mp2d_pkg::RST_STRIDE;
			state_q        <= mp2d_pkg::ST_RUN;
			col_q          <= '0;
			row_q          <= '0;
			slot_q         <= '0;
			ph_c_q         <= '0;
			ph_r_q         <= '0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					mp2d_pkg::REG_PLANE_WIDTH:  plane_width_q  <= cfg.data;
					mp2d_pkg::REG_PLANE_HEIGHT: plane_height_q <= cfg.data;
					mp2d_pkg::REG_POOL_SIZE:    pool_size_q    <= cfg.data[mp2d_pkg::POOL_BITS-1:0];
					mp2d_pkg::REG_STRIDE:       stride_q       <= cfg.data[mp2d_pkg::POOL_BITS-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				col_q  <= c_next;
				row_q  <= r_next;
				slot_q <= slot_next;
				ph_c_q <= ph_c_next;
				if (row_end) begin
					ph_r_q <= ph_r_next;
				end
			end

			if (cfg.valid && cfg.ready) begin
				state_q <= mp2d_pkg::ST_LOAD;
			end else begin
				unique case (state_q)
					mp2d_pkg::ST_RUN: ;
					mp2d_pkg::ST_LOAD: begin
						ph_c_q  <= a_c;
						ph_r_q  <= a_r;
						state_q <= mp2d_pkg::ST_ALIGN;
					end
					mp2d_pkg::ST_ALIGN: begin
						// reduce both phases modulo stride, one subtraction a cycle
						if (calc_t'(ph_c_q) >= s_c) begin
							ph_c_q <= PH_BITS'(calc_t'(ph_c_q) - s_c);
						end
						if (calc_t'(ph_r_q) >= s_c) begin
							ph_r_q <= PH_BITS'(calc_t'(ph_r_q) - s_c);
						end
						if (calc_t'(ph_c_q) < s_c && calc_t'(ph_r_q) < s_c) begin
							state_q <= mp2d_pkg::ST_RUN;
						end
					end
					default: state_q <= mp2d_pkg::ST_RUN;
				endcase
			end

			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= valid_s1 && produce_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			hmax_s1      <= hmax;
			produce_s1   <= produce;
			last_s1      <= is_last;
			src_slot_s1  <= src_slot_n;
			take_rows_s1 <= take_rows_n;
		end
		if (s1_go && valid_s1) begin
			pooled_value_q <= vmax;
			plane_last_q   <= last_s1;
		end
	end

	assign pooled.valid        = out_valid_q;
	assign pooled.pooled_value = pooled_value_q;
	assign pooled.plane_last   = plane_last_q;

`ifndef SYNTHESIS
	a_cfg_blocks_feed: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready |=> !feed.ready)
		else $error("feed accepted right after a register write");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mp2d_pkg::ST_RUN |-> calc_t'(ph_c_q) < s_c && calc_t'(ph_r_q) < s_c)
		else $error("window phase out of range while running");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(hmax_s1) && $stable(produce_s1))
		else $error("stage 1 item lost during output stall");
`endif

endmodule
